>>> sv/stable_priority_queue_assert.svh
// Assertion macros shared by the checker.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

>>> sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned AddrBits = 4;
  localparam int unsigned CntBits  = 5;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned PrioBits = 16;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  localparam logic [2:0] REG_CAPACITY = 3'd0;

  typedef struct packed {
    logic                       operation;
    logic signed [PrioBits-1:0] priority_req;
    logic [TagBits-1:0]         task_tag;
  } in_word_t;

  typedef struct packed {
    logic                  accepted;
    logic [CntBits-1:0]    entry_total;
    logic                  front_valid;
    logic [TagBits-1:0]    front_tag;
    logic [PrioBits-2:0]   front_priority;
  } out_word_t;

  typedef struct packed {
    logic [PrioBits-2:0] prio;
    logic [TagBits-1:0]  tag;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_CPL_RD,
    S_CPL_WR,
    S_FRONT_RD,
    S_OUT
  } state_e;

endpackage

>>> sv/stable_priority_queue.sv
// Stable priority queue: up to 16 entries kept in one single-port-write,
// registered-read memory, sorted by descending priority, equal priorities in
// arrival order. A word is taken when start_i is high and busy_o low; exactly
// one result word follows, shown for one cycle with res_valid_o high, and it
// cannot be stalled. A refused word goes straight to the front read; an add
// moves lower-priority entries back one at a time from the tail, then writes
// the new entry into the gap; a complete moves every later entry forward by
// one; busy_o stays high until the result cycle ends. Each moved entry costs
// one memory read and one write back. No clearing pass after reset.
module stable_priority_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  spq_pkg::in_word_t    cmd_i,
  output logic                 res_valid_o,
  output spq_pkg::out_word_t   res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [spq_pkg::CntBits-1:0] DepthCnt = spq_pkg::CntBits'(spq_pkg::Depth);

  spq_pkg::state_e state_q, state_d;

  logic [spq_pkg::CntBits-1:0]  cap_q;
  logic [spq_pkg::CntBits-1:0]  count_q, count_d;
  logic [spq_pkg::CntBits-1:0]  j_q, j_d;
  logic [spq_pkg::AddrBits-1:0] i_q, i_d;
  logic                         acc_q, acc_d;
  logic [spq_pkg::PrioBits-2:0] prio_q, prio_d;
  logic [spq_pkg::TagBits-1:0]  tag_q, tag_d;

  spq_pkg::slot_t               mem [spq_pkg::Depth];
  spq_pkg::slot_t               rd_q;
  logic                         mem_we, mem_re;
  logic [spq_pkg::AddrBits-1:0] waddr, raddr;
  spq_pkg::slot_t               wdata;

  logic [spq_pkg::CntBits-1:0]  limit;
  logic                         take, add_ok, cpl_ok, cfg_we;
  logic [spq_pkg::CntBits-1:0]  j_m1;

  assign limit  = (cap_q > DepthCnt) ? DepthCnt : cap_q;
  assign take   = start_i && (state_q == spq_pkg::S_IDLE);
  assign add_ok = !cmd_i.priority_req[spq_pkg::PrioBits-1] && (count_q < limit);
  assign cpl_ok = (count_q != '0);
  assign j_m1   = j_q - 1'b1;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == spq_pkg::REG_CAPACITY);
  assign prdata = (paddr[2] == spq_pkg::REG_CAPACITY[2]) ? 32'(cap_q) : 32'd0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (start_i) begin
          if (cmd_i.operation == spq_pkg::OP_ADD) begin
            state_d = add_ok ? spq_pkg::S_ADD_RD : spq_pkg::S_FRONT_RD;
          end else if (cpl_ok && count_q != 5'd1) begin
            state_d = spq_pkg::S_CPL_RD;
          end else begin
            state_d = spq_pkg::S_FRONT_RD;
          end
        end
      end
      spq_pkg::S_ADD_RD: begin
        state_d = (j_q == '0) ? spq_pkg::S_FRONT_RD : spq_pkg::S_ADD_CMP;
      end
      spq_pkg::S_ADD_CMP: begin
        state_d = (rd_q.prio >= prio_q) ? spq_pkg::S_FRONT_RD : spq_pkg::S_ADD_RD;
      end
      spq_pkg::S_CPL_RD: state_d = spq_pkg::S_CPL_WR;
      spq_pkg::S_CPL_WR: begin
        state_d = ((spq_pkg::CntBits'(i_q) + 1'b1) < count_q) ? spq_pkg::S_CPL_RD
                                                              : spq_pkg::S_FRONT_RD;
      end
      spq_pkg::S_FRONT_RD: state_d = spq_pkg::S_OUT;
      spq_pkg::S_OUT:      state_d = spq_pkg::S_IDLE;
      default:             state_d = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    j_d     = j_q;
    i_d     = i_q;
    acc_d   = acc_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    waddr   = '0;
    raddr   = '0;
    wdata   = rd_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (take) begin
          prio_d = cmd_i.priority_req[spq_pkg::PrioBits-2:0];
          tag_d  = cmd_i.task_tag;
          j_d    = count_q;
          i_d    = '0;
          if (cmd_i.operation == spq_pkg::OP_ADD) begin
            acc_d = add_ok;
            if (add_ok) count_d = count_q + 1'b1;
          end else begin
            acc_d = cpl_ok;
            if (cpl_ok) count_d = count_q - 1'b1;
          end
        end
      end
      spq_pkg::S_ADD_RD: begin
        if (j_q == '0) begin
          mem_we = 1'b1;
          waddr  = '0;
          wdata  = '{prio: prio_q, tag: tag_q};
        end else begin
          mem_re = 1'b1;
          raddr  = j_m1[spq_pkg::AddrBits-1:0];
        end
      end
      spq_pkg::S_ADD_CMP: begin
        mem_we = 1'b1;
        waddr  = j_q[spq_pkg::AddrBits-1:0];
        if (rd_q.prio >= prio_q) begin
          wdata = '{prio: prio_q, tag: tag_q};
        end else begin
          wdata = rd_q;
          j_d   = j_m1;
        end
      end
      spq_pkg::S_CPL_RD: begin
        mem_re = 1'b1;
        raddr  = i_q + 1'b1;
      end
      spq_pkg::S_CPL_WR: begin
        mem_we = 1'b1;
        waddr  = i_q;
        wdata  = rd_q;
        i_d    = i_q + 1'b1;
      end
      spq_pkg::S_FRONT_RD: begin
        mem_re = 1'b1;
        raddr  = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_valid_o = (state_q == spq_pkg::S_OUT);
    busy_o      = (state_q != spq_pkg::S_IDLE);
    res_o.accepted       = acc_q;
    res_o.entry_total    = count_q;
    res_o.front_valid    = (count_q != '0);
    res_o.front_tag      = (count_q != '0) ? rd_q.tag  : '0;
    res_o.front_priority = (count_q != '0) ? rd_q.prio : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      cap_q   <= DepthCnt;
      count_q <= '0;
      j_q     <= '0;
      i_q     <= '0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      j_q     <= j_d;
      i_q     <= i_d;
      acc_q   <= acc_d;
      if (cfg_we) begin
        cap_q <= pwdata[spq_pkg::CntBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

endmodule

>>> sv/spq_checker.sv
`include "stable_priority_queue_assert.svh"

module spq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               res_valid_o,
  input spq_pkg::out_word_t res_o
);

  `SPQ_ASSERT_NEXT(a_take_busy, start_i && !busy_o, busy_o)
  `SPQ_ASSERT_NEXT(a_res_frees, res_valid_o, !busy_o)
  `SPQ_ASSERT_IMPL(a_front_cnt, res_valid_o, res_o.front_valid == (res_o.entry_total != 5'd0))
  `SPQ_ASSERT_IMPL(a_empty_zero, res_valid_o && !res_o.front_valid,
                   res_o.front_tag == '0 && res_o.front_priority == '0)
  `SPQ_ASSERT_IMPL(a_res_busy, res_valid_o, busy_o)

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

>>> bench/testbench.sv
module testbench;
  import spq_pkg::*;

  localparam logic [2:0] CapAddr   = 3'(REG_CAPACITY * 4);
  localparam logic [2:0] SpareAddr = CapAddr + 3'd4;
  localparam int         IdleLimit = 2000;

  // shadow copy of the sorted list; computes the status word each command should yield
  class list_shadow;
    int                 slot_prio [Depth];
    logic [TagBits-1:0] slot_tag [Depth];
    int                 fill;
    logic [CntBits-1:0] cap_reg;
    out_word_t          due_status [$];
    int                 errors, words, adds_taken, completes_taken, refused, deepest;

    function new();
      foreach (slot_prio[i]) begin
        slot_prio[i] = -1;
        slot_tag[i]  = '0;
      end
      fill    = 0;
      cap_reg = CntBits'(Depth);
    endfunction

    function void set_capacity(logic [CntBits-1:0] v);
      cap_reg = v;
    endfunction

    function void take_word(in_word_t w);
      out_word_t r;
      int        p, pos, lim;
      bit        ok;
      words++;
      ok = 1'b0;
      if (w.operation == OP_COMPLETE) begin
        if (fill != 0) begin
          for (int i = 0; i + 1 < fill; i++) begin
            slot_prio[i] = slot_prio[i+1];
            slot_tag[i]  = slot_tag[i+1];
          end
          slot_prio[fill-1] = -1;
          slot_tag[fill-1]  = '0;
          fill--;
          ok = 1'b1;
          completes_taken++;
        end
      end else begin
        p   = $signed(w.priority_req);
        lim = (int'(cap_reg) > Depth) ? Depth : int'(cap_reg);
        if (p >= 0 && fill < lim) begin
          pos = 0;
          while (pos < fill && slot_prio[pos] >= p) pos++;
          for (int j = fill; j > pos; j--) begin
            slot_prio[j] = slot_prio[j-1];
            slot_tag[j]  = slot_tag[j-1];
          end
          slot_prio[pos] = p;
          slot_tag[pos]  = w.task_tag;
          fill++;
          ok = 1'b1;
          adds_taken++;
          if (fill > deepest) deepest = fill;
        end
      end
      if (!ok) refused++;
      r.accepted       = ok;
      r.entry_total    = CntBits'(fill);
      r.front_valid    = (fill != 0);
      r.front_tag      = (fill != 0) ? slot_tag[0] : '0;
      r.front_priority = (fill != 0) ? (PrioBits-1)'(slot_prio[0]) : '0;
      due_status.push_back(r);
    endfunction

    function void cmp_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_status(out_word_t got);
      out_word_t want;
      if (due_status.size() == 0) begin
        $display("%0t: status word with nothing outstanding, expected none, actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      want = due_status.pop_front();
      cmp_field("accepted", want.accepted, got.accepted);
      cmp_field("entry_total", want.entry_total, got.entry_total);
      cmp_field("front_valid", want.front_valid, got.front_valid);
      cmp_field("front_tag", want.front_tag, got.front_tag);
      cmp_field("front_priority", want.front_priority, got.front_priority);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_word_t    cmd_i   = '0;
  logic        res_valid_o;
  out_word_t   res_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  list_shadow  shadow = new();
  int          quiet  = 0;
  int          phases = 0;

  stable_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) shadow.match_status(res_o);
      if (start_i && !busy_o) shadow.take_word(cmd_i);
      if (psel && penable && pwrite && pready && paddr == CapAddr)
        shadow.set_capacity(pwdata[CntBits-1:0]);
      if (res_valid_o || (start_i && !busy_o) || (psel && penable && pready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    do @(posedge clk_i); while (quiet < IdleLimit);
    $display("%0t: no progress for %0d cycles", $time, IdleLimit);
    $display("Verification failed");
    $finish;
  end

  function automatic in_word_t mk_word(logic op, logic signed [PrioBits-1:0] prio,
                                       logic [TagBits-1:0] tag);
    in_word_t w;
    w.operation    = op;
    w.priority_req = prio;
    w.task_tag     = tag;
    return w;
  endfunction

  function automatic logic signed [PrioBits-1:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return PrioBits'($urandom_range(0, 32767)) | 16'h8000;
    if (sel < 45) return PrioBits'($urandom_range(0, 3));
    if (sel < 55) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh0000;
    return PrioBits'($urandom_range(0, 32767));
  endfunction

  // holds start until the word is taken; returns on the accepting edge
  task automatic push_word(in_word_t w);
    start_i <= 1'b1;
    cmd_i   <= w;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (shadow.due_status.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // bus is left in access phase; next transfer or apb_idle follows in the same step
  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic reg_read(logic [2:0] a);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(shadow.cap_reg)) begin
      $display("%0t: capacity readback mismatch, expected 0x%0h, actual 0x%0h",
               $time, shadow.cap_reg, prdata);
      shadow.errors++;
    end
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(int cap);
    reg_write(CapAddr, (32'($urandom) & ~32'h1f) | 32'(cap));
    reg_read(CapAddr);
    apb_idle();
    phases++;
  endtask

  task automatic run_phase(int n);
    int       burst_left, fill_pct;
    in_word_t w;
    burst_left = 0;
    fill_pct   = 80;
    for (int k = 0; k < n; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        fill_pct   = $urandom_range(0, 1) ? 80 : 30;
      end
      w.operation    = ($urandom_range(0, 99) < fill_pct) ? OP_ADD : OP_COMPLETE;
      w.priority_req = pick_prio();
      w.task_tag     = TagBits'($urandom);
      push_word(w);
      burst_left--;
      if (burst_left == 0 && k + 1 < n) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    in_word_t opening [$];
    in_word_t tight [$];
    int       caps [] = '{16, 0, 1, 31, 17, 3, 8, -1, 5, 16};
    int       cap;

    opening = '{
      mk_word(OP_COMPLETE, 16'sh1234, 16'hbeef),
      mk_word(OP_ADD, 16'sh8000, 16'h1111),
      mk_word(OP_ADD, 16'shffff, 16'h2222),
      mk_word(OP_ADD, 16'sh0000, 16'h0000),
      mk_word(OP_ADD, 16'sh7fff, 16'hffff),
      mk_word(OP_ADD, 16'sh7fff, 16'h0001),
      mk_word(OP_ADD, 16'sh0000, 16'haaaa),
      mk_word(OP_ADD, 16'sh5555, 16'h5555),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000),
      mk_word(OP_COMPLETE, 16'shffff, 16'hffff),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000)
    };
    tight = '{
      mk_word(OP_ADD, 16'sh0009, 16'h0a0a),
      mk_word(OP_ADD, 16'sh0009, 16'h0b0b),
      mk_word(OP_ADD, 16'sh0028, 16'h0c0c),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000),
      mk_word(OP_COMPLETE, 16'sh0000, 16'h0000)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_read(CapAddr);
    apb_idle();
    foreach (opening[i]) push_word(opening[i]);
    settle();

    // small list to hit the full case; a write to the unmapped word must not land
    set_capacity(2);
    reg_write(SpareAddr, $urandom);
    reg_read(CapAddr);
    apb_idle();
    foreach (tight[i]) push_word(tight[i]);
    settle();

    foreach (caps[i]) begin
      cap = (caps[i] < 0) ? $urandom_range(0, 31) : caps[i];
      set_capacity(cap);
      run_phase(cap == 0 ? 20 : 60);
      settle();
    end

    $display("Ran %0d words over %0d capacity settings: %0d adds taken, %0d completes taken,",
             shadow.words, phases, shadow.adds_taken, shadow.completes_taken);
    $display("%0d refused, list depth reached %0d.", shadow.refused, shadow.deepest);
    if (shadow.errors == 0 && shadow.due_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
